>>> design/tsr_pkg.sv
// Shared types, constants and helpers for the tile scanline renderer.
// No dependencies; every other design file imports this package.
package tsr_pkg;

   localparam int VRAM_BYTES       = 8192;
   localparam int VRAM_AW          = $clog2(VRAM_BYTES);
   localparam int OAM_BYTES        = 160;
   localparam int OAM_AW           = 8;
   localparam int SPRITES_PER_LINE = 10;
   localparam int SPRITE_ENTRIES   = 40;
   localparam int SCREEN_WIDTH     = 160;
   localparam int LIST_AW          = 4;

   localparam logic [VRAM_AW-1:0] MAP_LOW  = 13'h1800;
   localparam logic [VRAM_AW-1:0] MAP_HIGH = 13'h1C00;

   typedef enum logic [1:0] {
      CMD_WR_VRAM    = 2'd0,
      CMD_WR_OAM     = 2'd1,
      CMD_START_LINE = 2'd2,
      CMD_RENDER     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_LCDC = 3'd0,
      CSR_SCY  = 3'd1,
      CSR_SCX  = 3'd2,
      CSR_WY   = 3'd3,
      CSR_WX   = 3'd4,
      CSR_BGP  = 3'd5,
      CSR_OBP0 = 3'd6,
      CSR_OBP1 = 3'd7
   } csr_index_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_LINE,
      S_SCAN_Y, S_SCAN_CHK, S_SCAN_X,
      S_SORT_LOAD, S_SORT_STEP, S_SORT_END,
      S_PIX, S_BG_TILE, S_BG_LO, S_BG_HI,
      S_SPR_Y, S_SPR_X, S_SPR_T, S_SPR_A, S_SPR_CHK, S_SPR_LO, S_SPR_HI,
      S_OUT
   } state_type;

   typedef struct packed {
      logic               we;
      logic [VRAM_AW-1:0] addr;
      logic [7:0]         wdata;
   } vram_req_type;

   typedef struct packed {
      logic              we;
      logic [OAM_AW-1:0] addr;
      logic [7:0]        wdata;
   } oam_req_type;

   typedef struct packed {
      logic [5:0] entry;
      logic [7:0] x;
   } spr_type;

   // Fixed green color table indexed by shade
   function automatic logic [15:0] green_color(input logic [1:0] shade);
      logic [15:0] c;
      unique case (shade)
         2'd0: c = 16'h8DD3;
         2'd1: c = 16'h441B;
         2'd2: c = 16'h3315;
         default: c = 16'h2251;
      endcase
      return c;
   endfunction

endpackage

>>> design/tsr_vram.sv
// Video memory: 8 KiB single-port RAM with registered read data.
// Depends on tsr_pkg for the request struct and sizes.
module tsr_vram
   import tsr_pkg::*;
(
   input  logic         clock,
   input  vram_req_type req,
   output logic [7:0]   rdata
);

   logic [7:0] mem [VRAM_BYTES];
   logic [7:0] rdata_ff;

   // Write or read one byte per cycle
   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.addr] <= req.wdata;
      end
      rdata_ff <= mem[req.addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/tsr_oam.sv
// Sprite table: 160-byte single-port RAM with registered read data.
// Depends on tsr_pkg; addresses beyond the table read as zero.
module tsr_oam
   import tsr_pkg::*;
(
   input  logic        clock,
   input  oam_req_type req,
   output logic [7:0]  rdata
);

   logic [7:0] mem [OAM_BYTES];
   logic [7:0] rdata_ff;
   logic       in_range;

   assign in_range = ({1'b0, req.addr} < 9'(OAM_BYTES));

   // Drop out-of-range writes, read zero beyond the table
   always_ff @(posedge clock) begin
      if (req.we && in_range) begin
         mem[req.addr] <= req.wdata;
      end
      rdata_ff <= in_range ? mem[req.addr] : 8'd0;
   end

   assign rdata = rdata_ff;

endmodule

>>> design/tsr_core.sv
// Sequencer and shared datapath: registers, line setup, sprite scan and sort,
// pixel composition. Depends on tsr_pkg; drives the two memory ports.
module tsr_core
   import tsr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_cmd,
   input  logic [12:0]  req_mem_addr,
   input  logic [7:0]   req_mem_data,
   input  logic [7:0]   req_line_number,
   input  logic [7:0]   req_column,
   output logic         rsp_strobe,
   output logic [1:0]   rsp_shade,
   output logic [15:0]  rsp_pixel_color,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [7:0]   csr_data,
   output vram_req_type vram_req,
   input  logic [7:0]   vram_rdata,
   output oam_req_type  oam_req,
   input  logic [7:0]   oam_rdata
);

   state_type state_ff, state_in;

   logic [7:0] lcdc_ff, scy_ff, scx_ff, wy_ff, wx_ff, bgp_ff, obp0_ff, obp1_ff;

   logic [VRAM_AW-1:0] clr_ff;
   logic [7:0]         line_ff, col_ff;
   logic [7:0]         win_cnt_ff, win_row_ff;
   logic               win_seen_ff, win_on_ff;
   spr_type            list_ff [SPRITES_PER_LINE];
   logic [LIST_AW-1:0] cnt_ff, idx_i_ff, pass_ff;
   logic [5:0]         ent_ff;
   spr_type            carry_ff;

   logic [7:0]  tile_ff, lo_ff, sy_ff, sx_ff, stile_ff, attr_ff, pal_ff;
   logic [2:0]  prow_ff, pcol_ff, sbit_ff;
   logic [10:0] saddr_ff;
   logic [1:0]  idx_ff;

   logic accept;
   cmd_type cmd;

   assign accept = start && (state_ff == S_IDLE);
   assign cmd    = cmd_type'(req_cmd);
   assign busy   = (state_ff != S_IDLE);

   // Shared vertical cover check: scan reads fresh bytes, pixel uses the held byte
   logic [7:0] y_sel;
   logic [9:0] dy, dx, height;
   logic       covers, x_hit, tall;

   assign tall   = lcdc_ff[2];
   assign height = tall ? 10'd16 : 10'd8;
   assign y_sel  = (state_ff == S_SCAN_CHK) ? oam_rdata : sy_ff;
   assign dy     = {2'b0, line_ff} + 10'd16 - {2'b0, y_sel};
   assign covers = !dy[9] && (dy < height);
   assign dx     = {2'b0, col_ff} + 10'd8 - {2'b0, sx_ff};
   assign x_hit  = !dx[9] && (dx < 10'd8);

   // Sprite tile row with vertical flip and tall-sprite tile pairing
   logic [3:0] srow;
   logic [7:0] stile_eff;
   always_comb begin
      srow = dy[3:0];
      if (oam_rdata[6]) begin
         srow = tall ? ~dy[3:0] : {1'b0, ~dy[2:0]};
      end
      stile_eff = tall ? {stile_ff[7:1], srow[3]} : stile_ff;
   end

   // Background or window plane coordinates for this pixel
   logic       use_win;
   logic [7:0] prow, pcol;
   logic [VRAM_AW-1:0] map_base, map_addr;
   always_comb begin
      use_win  = win_on_ff && (({1'b0, col_ff} + 9'd7) >= {1'b0, wx_ff});
      prow     = use_win ? win_row_ff : line_ff + scy_ff;
      pcol     = use_win ? col_ff + 8'd7 - wx_ff : col_ff + scx_ff;
      map_base = (use_win ? lcdc_ff[6] : lcdc_ff[3]) ? MAP_HIGH : MAP_LOW;
      map_addr = map_base | {3'b0, prow[7:3], pcol[7:3]};
   end

   // Sprite list read and write ports
   logic [LIST_AW-1:0] rd_idx, last_idx;
   spr_type            rd_spr;
   logic               carry_after;
   assign last_idx = cnt_ff - 4'd1;
   always_comb begin
      unique case (state_ff)
         S_SORT_LOAD: rd_idx = '0;
         S_SORT_STEP: rd_idx = idx_i_ff;
         default:     rd_idx = idx_i_ff;
      endcase
   end
   assign rd_spr      = list_ff[rd_idx];
   assign carry_after = !((carry_ff.x > rd_spr.x) ||
                          ((carry_ff.x == rd_spr.x) && (carry_ff.entry > rd_spr.entry)));

   logic [1:0] spix;
   assign spix = {vram_rdata[sbit_ff], lo_ff[sbit_ff]};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:     if (&clr_ff) state_in = S_IDLE;
         S_IDLE: begin
            if (accept && cmd == CMD_START_LINE) begin
               state_in = S_LINE;
            end else if (accept && cmd == CMD_RENDER &&
                         req_column < 8'(SCREEN_WIDTH)) begin
               state_in = S_PIX;
            end
         end
         S_LINE:      state_in = S_SCAN_Y;
         S_SCAN_Y:    state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (covers) begin
               state_in = S_SCAN_X;
            end else if (ent_ff == 6'(SPRITE_ENTRIES - 1)) begin
               state_in = S_SORT_LOAD;
            end else begin
               state_in = S_SCAN_Y;
            end
         end
         S_SCAN_X: begin
            if (cnt_ff == 4'(SPRITES_PER_LINE - 1) ||
                ent_ff == 6'(SPRITE_ENTRIES - 1)) begin
               state_in = S_SORT_LOAD;
            end else begin
               state_in = S_SCAN_Y;
            end
         end
         S_SORT_LOAD: state_in = (cnt_ff < 4'd2) ? S_IDLE : S_SORT_STEP;
         S_SORT_STEP: if (idx_i_ff == last_idx) state_in = S_SORT_END;
         S_SORT_END:  state_in = (pass_ff == last_idx) ? S_IDLE : S_SORT_LOAD;
         S_PIX: begin
            if (lcdc_ff[0]) begin
               state_in = S_BG_TILE;
            end else if (lcdc_ff[1] && cnt_ff != '0) begin
               state_in = S_SPR_Y;
            end else begin
               state_in = S_OUT;
            end
         end
         S_BG_TILE:   state_in = S_BG_LO;
         S_BG_LO:     state_in = S_BG_HI;
         S_BG_HI:     state_in = (lcdc_ff[1] && cnt_ff != '0) ? S_SPR_Y : S_OUT;
         S_SPR_Y:     state_in = S_SPR_X;
         S_SPR_X:     state_in = S_SPR_T;
         S_SPR_T:     state_in = S_SPR_A;
         S_SPR_A:     state_in = S_SPR_CHK;
         S_SPR_CHK: begin
            if (covers && x_hit) begin
               state_in = S_SPR_LO;
            end else begin
               state_in = (idx_i_ff == last_idx) ? S_OUT : S_SPR_Y;
            end
         end
         S_SPR_LO:    state_in = S_SPR_HI;
         S_SPR_HI:    state_in = (idx_i_ff == last_idx) ? S_OUT : S_SPR_Y;
         S_OUT:       state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Memory requests and result strobe
   always_comb begin
      vram_req = '{we: 1'b0, addr: map_addr, wdata: 8'd0};
      oam_req  = '{we: 1'b0, addr: {rd_spr.entry, 2'd0}, wdata: 8'd0};
      unique case (state_ff)
         S_CLEAR: begin
            vram_req = '{we: 1'b1, addr: clr_ff, wdata: 8'd0};
            oam_req  = '{we: 1'b1, addr: clr_ff[OAM_AW-1:0], wdata: 8'd0};
            oam_req.we = (clr_ff < 13'(OAM_BYTES));
         end
         S_IDLE: begin
            vram_req = '{we: accept && cmd == CMD_WR_VRAM, addr: req_mem_addr,
                         wdata: req_mem_data};
            oam_req  = '{we: accept && cmd == CMD_WR_OAM &&
                             req_mem_addr < 13'(OAM_BYTES),
                         addr: req_mem_addr[OAM_AW-1:0], wdata: req_mem_data};
         end
         S_SCAN_Y:  oam_req.addr = {ent_ff, 2'd0};
         S_SCAN_CHK: oam_req.addr = {ent_ff, 2'd1};
         S_BG_TILE: vram_req.addr = {~(lcdc_ff[4] | vram_rdata[7]), vram_rdata,
                                     prow_ff, 1'b0};
         S_BG_LO:   vram_req.addr = {~(lcdc_ff[4] | tile_ff[7]), tile_ff,
                                     prow_ff, 1'b1};
         S_SPR_Y:   oam_req.addr = {rd_spr.entry, 2'd0};
         S_SPR_X:   oam_req.addr = {rd_spr.entry, 2'd1};
         S_SPR_T:   oam_req.addr = {rd_spr.entry, 2'd2};
         S_SPR_A:   oam_req.addr = {rd_spr.entry, 2'd3};
         S_SPR_CHK: vram_req.addr = {1'b0, stile_eff, srow[2:0], 1'b0};
         S_SPR_LO:  vram_req.addr = {1'b0, saddr_ff, 1'b1};
         default: begin
         end
      endcase
   end

   assign rsp_strobe      = (state_ff == S_OUT);
   assign rsp_shade       = 2'(pal_ff >> {idx_ff, 1'b0});
   assign rsp_pixel_color = green_color(rsp_shade);

   // Advance state and control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_ff      <= '0;
         lcdc_ff     <= 8'd145;
         scy_ff      <= 8'd0;
         scx_ff      <= 8'd0;
         wy_ff       <= 8'd0;
         wx_ff       <= 8'd0;
         bgp_ff      <= 8'd252;
         obp0_ff     <= 8'd255;
         obp1_ff     <= 8'd255;
         line_ff     <= 8'd0;
         win_cnt_ff  <= 8'd0;
         win_row_ff  <= 8'd0;
         win_seen_ff <= 1'b0;
         win_on_ff   <= 1'b0;
         cnt_ff      <= '0;
         for (int k = 0; k < SPRITES_PER_LINE; k++) begin
            list_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + 13'd1;
         end

         // Hold configuration registers
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_LCDC: lcdc_ff <= csr_data;
               CSR_SCY:  scy_ff  <= csr_data;
               CSR_SCX:  scx_ff  <= csr_data;
               CSR_WY:   wy_ff   <= csr_data;
               CSR_WX:   wx_ff   <= csr_data;
               CSR_BGP:  bgp_ff  <= csr_data;
               CSR_OBP0: obp0_ff <= csr_data;
               CSR_OBP1: obp1_ff <= csr_data;
               default: begin
               end
            endcase
         end

         if (accept && cmd == CMD_START_LINE) begin
            line_ff <= req_line_number;
         end

         // Window trigger and row counter at line start
         if (state_ff == S_LINE) begin
            logic       seen;
            logic [7:0] wcnt;
            logic       won;
            seen = (line_ff == 8'd0) ? 1'b0 : win_seen_ff;
            wcnt = (line_ff == 8'd0) ? 8'd0 : win_cnt_ff;
            if (wy_ff == line_ff) begin
               seen = 1'b1;
            end
            won = lcdc_ff[0] && lcdc_ff[5] && seen && (wx_ff < 8'd167);
            win_seen_ff <= seen;
            win_on_ff   <= won;
            win_cnt_ff  <= won ? wcnt + 8'd1 : wcnt;
            if (won) begin
               win_row_ff <= wcnt;
            end
            cnt_ff <= '0;
         end

         // Append a covering sprite, then bubble the list into draw order
         if (state_ff == S_SCAN_X) begin
            list_ff[cnt_ff] <= '{entry: ent_ff, x: oam_rdata};
            cnt_ff          <= cnt_ff + 4'd1;
         end
         if (state_ff == S_SORT_STEP) begin
            list_ff[idx_i_ff - 4'd1] <= carry_after ? rd_spr : carry_ff;
         end
         if (state_ff == S_SORT_END) begin
            list_ff[last_idx] <= carry_ff;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            col_ff <= req_column;
         end
         S_LINE: begin
            ent_ff  <= '0;
            pass_ff <= 4'd1;
         end
         S_SCAN_CHK: begin
            if (!covers) begin
               ent_ff <= ent_ff + 6'd1;
            end
         end
         S_SCAN_X: begin
            ent_ff <= ent_ff + 6'd1;
         end
         S_SORT_LOAD: begin
            carry_ff <= rd_spr;
            idx_i_ff <= 4'd1;
         end
         S_SORT_STEP: begin
            if (!carry_after) begin
               carry_ff <= rd_spr;
            end
            idx_i_ff <= idx_i_ff + 4'd1;
         end
         S_SORT_END: begin
            pass_ff <= pass_ff + 4'd1;
         end
         S_PIX: begin
            prow_ff  <= prow[2:0];
            pcol_ff  <= pcol[2:0];
            idx_ff   <= 2'd0;
            pal_ff   <= bgp_ff;
            idx_i_ff <= '0;
         end
         S_BG_TILE: tile_ff <= vram_rdata;
         S_BG_LO:   lo_ff   <= vram_rdata;
         S_BG_HI: begin
            idx_ff <= {vram_rdata[~pcol_ff], lo_ff[~pcol_ff]};
         end
         S_SPR_X:   sy_ff    <= oam_rdata;
         S_SPR_T:   sx_ff    <= oam_rdata;
         S_SPR_A:   stile_ff <= oam_rdata;
         S_SPR_CHK: begin
            attr_ff  <= oam_rdata;
            saddr_ff <= {stile_eff, srow[2:0]};
            sbit_ff  <= oam_rdata[5] ? dx[2:0] : ~dx[2:0];
            if (!(covers && x_hit)) begin
               idx_i_ff <= idx_i_ff + 4'd1;
            end
         end
         S_SPR_LO:  lo_ff <= vram_rdata;
         S_SPR_HI: begin
            // Drop transparent pixels and behind-background pixels over color
            if (spix != 2'd0 && !(attr_ff[7] && idx_ff != 2'd0)) begin
               idx_ff <= spix;
               pal_ff <= attr_ff[4] ? obp1_ff : obp0_ff;
            end
            idx_i_ff <= idx_i_ff + 4'd1;
         end
         default: begin
         end
      endcase
   end

endmodule

>>> design/tile_scanline_renderer_top.sv
// Top level: ties the sequencer to the video memory and sprite table; uses tsr_pkg.
// Pixel item: background tile number and two pattern bytes (skipped with background off), then
// four table bytes per listed sprite (at most 10) and two pattern bytes per hit; strobed in S_OUT.
// Start-line item: setup, then the Y byte of each sprite entry scanned (40 at most) and the X
// byte of each covering one, then a bubble sort of up to 9 passes. Memory writes keep busy low.
// Synchronous reset; busy stays high while memories clear; receiver cannot stall.
module tile_scanline_renderer_top
   import tsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [12:0] req_mem_addr,
   input  logic [7:0]  req_mem_data,
   input  logic [7:0]  req_line_number,
   input  logic [7:0]  req_column,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_shade,
   output logic [15:0] rsp_pixel_color,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   vram_req_type vram_req;
   oam_req_type  oam_req;
   logic [7:0]   vram_rdata, oam_rdata;

   tsr_core u_core (
      .clock, .reset, .start, .busy,
      .req_cmd, .req_mem_addr, .req_mem_data, .req_line_number, .req_column,
      .rsp_strobe, .rsp_shade, .rsp_pixel_color,
      .csr_we, .csr_index, .csr_data,
      .vram_req, .vram_rdata, .oam_req, .oam_rdata
   );

   tsr_vram u_vram (
      .clock,
      .req   (vram_req),
      .rdata (vram_rdata)
   );

   tsr_oam u_oam (
      .clock,
      .req   (oam_req),
      .rdata (oam_rdata)
   );

endmodule
